### sv/opi_pkg.sv
// opi_pkg: shared constants, types and the arctangent table of the pose integrator
// no dependencies; imported by odometry_pose_integrator_unit and opi_checker
package opi_pkg;

	// angle quantization and rotation step count
	localparam int ANGLE_BITS     = 16;
	localparam int ROTATION_STEPS = 16;
	localparam int TABLE_LEN      = 24;
	localparam int STEPS          = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;
	localparam int ANGLE_SH       = 32 - ANGLE_BITS;
	localparam int CNT_W          = $clog2(STEPS);

	// datapath widths
	localparam int POS_W  = 32;
	localparam int VEC_W  = 36;
	localparam int HALF_W = VEC_W / 2;
	localparam int ANG_W  = 34;
	localparam int GAIN_W = 31;
	localparam int PROD_W = HALF_W + 1 + GAIN_W;
	localparam int ACC_W  = 66;
	localparam int OUT_SH = 38;
	localparam int ROT_W  = ACC_W - OUT_SH;

	// inverse cordic gain, q30
	localparam logic signed [GAIN_W-1:0] INV_GAIN = 31'sh26DD3B6A;
	localparam logic signed [ACC_W-1:0]  ACC_ROUND = ACC_W'(64'sd1 <<< (OUT_SH - 1));

	// angles in 2^-32 turn
	localparam logic [ANG_W-1:0]        ANG_MASK = ~ANG_W'((64'd1 << ANGLE_SH) - 64'd1);
	localparam logic signed [ANG_W-1:0] QUARTER  = ANG_W'(64'sd1 <<< 30);
	localparam logic signed [ANG_W-1:0] HALF     = ANG_W'(64'sd1 <<< 31);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROT,
		ST_SCALE,
		ST_DONE
	} opi_state_t;

	// gain multiply phases: low and high halves of x, then of y
	typedef enum logic [2:0] {
		PH_X_LO,
		PH_X_HI,
		PH_Y_LO,
		PH_Y_HI,
		PH_Y_SUM
	} opi_phase_t;

	// atan(2^-i) in 2^-32 turn, rounded half up to ANGLE_BITS bits of a turn
	function automatic logic signed [ANG_W-1:0] atan_step(input logic [CNT_W-1:0] idx);
		logic [32:0] raw;
		logic [32:0] rnd;
		case (int'(idx))
			0:       raw = 33'h020000000;
			1:       raw = 33'h012E4051E;
			2:       raw = 33'h009FB385B;
			3:       raw = 33'h0051111D4;
			4:       raw = 33'h0028B0D43;
			5:       raw = 33'h00145D7E1;
			6:       raw = 33'h000A2F61E;
			7:       raw = 33'h000517C55;
			8:       raw = 33'h00028BE53;
			9:       raw = 33'h000145F2F;
			10:      raw = 33'h0000A2F98;
			11:      raw = 33'h0000517CC;
			12:      raw = 33'h000028BE6;
			13:      raw = 33'h0000145F3;
			14:      raw = 33'h00000A2FA;
			15:      raw = 33'h00000517D;
			16:      raw = 33'h0000028BE;
			17:      raw = 33'h00000145F;
			18:      raw = 33'h000000A30;
			19:      raw = 33'h000000518;
			20:      raw = 33'h00000028C;
			21:      raw = 33'h000000146;
			22:      raw = 33'h0000000A3;
			23:      raw = 33'h000000051;
			default: raw = 33'h000000000;
		endcase
		rnd = raw + (33'd1 << (ANGLE_SH - 1));
		rnd = (rnd >> ANGLE_SH) << ANGLE_SH;
		return ANG_W'(rnd);
	endfunction

endpackage

### sv/odometry_pose_integrator_unit.sv
// odometry_pose_integrator_unit: planar dead-reckoning pose integrator, top level
// depends on opi_pkg; one shared cordic shift-add unit and one 19x31 multiplier
// one step at a time: the cordic loop and then four passes through the shared gain
// multiplier finish before the next input beat is taken; in_ready is low meanwhile
// reset: arst_n clears the pose to the origin, the sequencer to idle and out_valid
module odometry_pose_integrator_unit
	import opi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    restart,
	input  logic signed [23:0]      delta_x,
	input  logic signed [23:0]      delta_y,
	input  logic signed [15:0]      delta_heading,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [POS_W-1:0] pose_x,
	output logic signed [POS_W-1:0] pose_y,
	output logic signed [15:0]      pose_heading,
	output logic                    saturated
);

	// sequencer
	opi_state_t state_q, state_d;
	logic [CNT_W-1:0] step_q;
	opi_phase_t       ph_q;

	// global pose
	logic signed [POS_W-1:0] gx_q, gy_q;
	logic signed [15:0]      heading_q;
	logic signed [15:0]      dh_q;

	// cordic vector and residual angle
	logic signed [VEC_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;

	// gain multiply
	logic signed [HALF_W:0]   mul_op;
	logic signed [PROD_W-1:0] mul_prod;
	logic signed [PROD_W-1:0] p_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ROT_W-1:0]  rx_q;
	logic signed [ROT_W-1:0]  ry;

	// output beat register
	logic                    out_valid_q;
	logic signed [POS_W-1:0] pose_x_q, pose_y_q;
	logic signed [15:0]      pose_heading_q;
	logic                    saturated_q;

	// handshake strobes
	logic accept;
	logic load_out;

	// start of rotation: quantized heading and half-turn fold
	logic signed [15:0]      h_start;
	logic signed [ANG_W-1:0] z_raw, z_quant, z_start;
	logic signed [VEC_W-1:0] dx_ext, dy_ext, x_start, y_start;

	// one cordic micro-rotation
	logic signed [VEC_W-1:0] xs, ys;
	logic signed [ANG_W-1:0] a_step;

	// saturating position update
	logic signed [POS_W:0]   sum_x, sum_y;
	logic                    clip_x, clip_y;
	logic signed [POS_W-1:0] new_x, new_y;

	// ---------------------------------------------------------------------
	// sequencer: idle -> rot -> scale (5 phases) -> done
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		load_out = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = ST_ROT;
				end
			end
			ST_ROT: begin
				if (step_q == CNT_W'(STEPS - 1)) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (ph_q == PH_Y_SUM) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold the finished result until the output register frees up
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			ph_q   <= PH_X_LO;
		end else begin
			if (accept) begin
				step_q <= '0;
			end else if (state_q == ST_ROT) begin
				step_q <= step_q + CNT_W'(1);
			end
			if (state_q != ST_SCALE) begin
				ph_q <= PH_X_LO;
			end else begin
				unique case (ph_q)
					PH_X_LO: ph_q <= PH_X_HI;
					PH_X_HI: ph_q <= PH_Y_LO;
					PH_Y_LO: ph_q <= PH_Y_HI;
					PH_Y_HI: ph_q <= PH_Y_SUM;
					default: ph_q <= PH_X_LO;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// rotation setup on the input beat
	// ---------------------------------------------------------------------
	// restart rotates from heading zero
	assign h_start = restart ? 16'sd0 : heading_q;
	// heading in 2^-32 turn, low bits cleared down to ANGLE_BITS of a turn
	assign z_raw   = {{(ANG_W - 32){h_start[15]}}, h_start, 16'h0000};
	assign z_quant = z_raw & ANG_MASK;
	// robot-frame step scaled to q.8
	assign dx_ext  = {{(VEC_W - 32){delta_x[23]}}, delta_x, 8'h00};
	assign dy_ext  = {{(VEC_W - 32){delta_y[23]}}, delta_y, 8'h00};

	// fold angles beyond a quarter turn back by a half turn and negate the vector
	always_comb begin
		z_start = z_quant;
		x_start = dx_ext;
		y_start = dy_ext;
		priority if (z_quant > QUARTER) begin
			z_start = z_quant - HALF;
			x_start = -dx_ext;
			y_start = -dy_ext;
		end else if (z_quant < -QUARTER) begin
			z_start = z_quant + HALF;
			x_start = -dx_ext;
			y_start = -dy_ext;
		end
	end

	// ---------------------------------------------------------------------
	// shared cordic unit: one micro-rotation per cycle
	// ---------------------------------------------------------------------
	// arithmetic shift gives the floor of the division by 2^i
	assign xs     = x_q >>> step_q;
	assign ys     = y_q >>> step_q;
	assign a_step = atan_step(step_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= x_start;
			y_q <= y_start;
			z_q <= z_start;
		end else if (state_q == ST_ROT) begin
			if (!z_q[ANG_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a_step;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a_step;
			end
		end
	end

	// ---------------------------------------------------------------------
	// gain correction: each coordinate is split in halves, multiplied by the
	// inverse gain one half at a time, and summed with the rounding constant
	// ---------------------------------------------------------------------
	always_comb begin
		unique case (ph_q)
			PH_X_LO:  mul_op = {1'b0, x_q[HALF_W-1:0]};
			PH_X_HI:  mul_op = {x_q[VEC_W-1], x_q[VEC_W-1:HALF_W]};
			PH_Y_LO:  mul_op = {1'b0, y_q[HALF_W-1:0]};
			PH_Y_HI:  mul_op = {y_q[VEC_W-1], y_q[VEC_W-1:HALF_W]};
			default:  mul_op = '0;
		endcase
	end

	assign mul_prod = mul_op * INV_GAIN;

	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			p_q <= mul_prod;
			unique case (ph_q)
				PH_X_LO: begin
				end
				PH_X_HI: begin
					acc_q <= ACC_ROUND + ACC_W'(p_q);
				end
				PH_Y_LO: begin
					acc_q <= acc_q + (ACC_W'(p_q) <<< HALF_W);
				end
				PH_Y_HI: begin
					// x product complete: keep its rounded top bits
					rx_q  <= acc_q[ACC_W-1:OUT_SH];
					acc_q <= ACC_ROUND + ACC_W'(p_q);
				end
				PH_Y_SUM: begin
					acc_q <= acc_q + (ACC_W'(p_q) <<< HALF_W);
				end
				default: begin
				end
			endcase
		end
	end

	assign ry = acc_q[ACC_W-1:OUT_SH];

	// ---------------------------------------------------------------------
	// saturating accumulate into the global position
	// ---------------------------------------------------------------------
	assign sum_x  = {gx_q[POS_W-1], gx_q} + (POS_W + 1)'(rx_q);
	assign sum_y  = {gy_q[POS_W-1], gy_q} + (POS_W + 1)'(ry);
	assign clip_x = sum_x[POS_W] != sum_x[POS_W-1];
	assign clip_y = sum_y[POS_W] != sum_y[POS_W-1];

	always_comb begin
		new_x = sum_x[POS_W-1:0];
		new_y = sum_y[POS_W-1:0];
		if (clip_x) begin
			new_x = sum_x[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
		end
		if (clip_y) begin
			new_y = sum_y[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
		end
	end

	// global pose: cleared on a restart beat, updated when the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q      <= '0;
			gy_q      <= '0;
			heading_q <= '0;
		end else if (accept && restart) begin
			gx_q      <= '0;
			gy_q      <= '0;
			heading_q <= '0;
		end else if (load_out) begin
			gx_q      <= new_x;
			gy_q      <= new_y;
			heading_q <= heading_q + dh_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dh_q <= delta_heading;
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pose_x_q       <= new_x;
			pose_y_q       <= new_y;
			pose_heading_q <= heading_q + dh_q;
			saturated_q    <= clip_x | clip_y;
		end
	end

	assign out_valid    = out_valid_q;
	assign pose_x       = pose_x_q;
	assign pose_y       = pose_y_q;
	assign pose_heading = pose_heading_q;
	assign saturated    = saturated_q;

endmodule

### sv/opi_checker.sv
// opi_checker: port-level assertions for the pose integrator, bound to the top level
// depends on opi_pkg and odometry_pose_integrator_unit
module opi_checker
	import opi_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [POS_W-1:0] pose_x,
	input logic signed [POS_W-1:0] pose_y,
	input logic signed [15:0]      pose_heading,
	input logic                    saturated
);

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pose_x) && $stable(pose_y)
			&& $stable(pose_heading) && $stable(saturated))
		else $error("result beat changed while stalled");

	// one step at a time: busy right after an input beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a step is in flight");

	// a new result only appears at the end of a step
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a step in flight");

	// a clipped step leaves a coordinate at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> pose_x == POS_MAX || pose_x == POS_MIN
			|| pose_y == POS_MAX || pose_y == POS_MIN)
		else $error("saturated flag without a clipped coordinate");

endmodule

bind odometry_pose_integrator_unit opi_checker u_opi_checker (.*);
